FILE: hdl/rsf_pkg.sv
// Shared types and constants for the RGB spatial filter.
// Holds field widths, operation and register codes and the tap control struct.
// No dependencies.
package rsf_pkg;

	// Field widths of the streamed items
	localparam int ROW_W      = 9;
	localparam int COL_W      = 9;
	localparam int CIDX_W     = 6;
	localparam int COEF_W     = 16;
	localparam int PIX_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SIZE_W     = 10;
	localparam int RAD_W      = 2;

	// Arithmetic
	localparam int PROD_W      = COEF_W + CHAN_W + 1;
	localparam int SCALE_SHIFT = 24;

	// Operation codes carried in tuser
	localparam logic [OP_W-1:0] OP_LOAD_COEF   = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_PIXEL = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd3;

	// Colour channel codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// Control that travels with one window tap
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tap_t;

endpackage

FILE: hdl/rsf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module rsf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 262144
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/rsf_seq.sv
// Window sequencer: walks the taps of the square window one per cycle,
// clamps each neighbour into the frame and forms the store addresses.
// Depends on rsf_pkg.
module rsf_seq #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 3
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [rsf_pkg::ROW_W-1:0]                    row,
	input  logic [rsf_pkg::COL_W-1:0]                    column,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]              radius,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]               frame_width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]              frame_height,
	output rsf_pkg::tap_t                                tap,
	output logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] kern_addr,
	output logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
		$clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0]           pix_addr
);

	import rsf_pkg::*;

	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int DW    = $clog2(2*MAX_RADIUS + 1);
	localparam int KTAPS = (2*MAX_RADIUS + 1) * (2*MAX_RADIUS + 1);
	localparam int KW    = $clog2(KTAPS);
	localparam int FWW   = $clog2(MAX_WIDTH + 1);
	localparam int FHW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW0   = (FWW > FHW) ? FWW : FHW;
	localparam int CW    = ((CW0 > ROW_W + 1) ? CW0 : ROW_W + 1) + 2;

	logic              run_q;
	logic [DW-1:0]     dr_q;
	logic [DW-1:0]     dc_q;
	logic [KW-1:0]     k_q;
	logic [DW-1:0]     span;
	logic              last_dc;
	logic              last_dr;
	logic signed [CW-1:0] y_c;
	logic signed [CW-1:0] x_c;
	logic [FHW-1:0]    fh_m1;
	logic [FWW-1:0]    fw_m1;
	logic [YW-1:0]     y_clamp;
	logic [XW-1:0]     x_clamp;
	tap_t              tap_s1;
	logic [YW-1:0]     y_s1;
	logic [XW-1:0]     x_s1;
	logic [KW-1:0]     k_s1;

	assign span    = DW'({radius, 1'b0});
	assign last_dc = (dc_q == span);
	assign last_dr = (dr_q == span);
	assign fh_m1   = frame_height - FHW'(1);
	assign fw_m1   = frame_width - FWW'(1);

	// Neighbour coordinates, clamped into the frame to replicate the edges
	always_comb begin
		y_c = $signed(CW'(row)) + $signed(CW'(dr_q)) - $signed(CW'(radius));
		x_c = $signed(CW'(column)) + $signed(CW'(dc_q)) - $signed(CW'(radius));
		if (y_c < 0) begin
			y_clamp = '0;
		end else if (y_c >= $signed(CW'(frame_height))) begin
			y_clamp = fh_m1[YW-1:0];
		end else begin
			y_clamp = y_c[YW-1:0];
		end
		if (x_c < 0) begin
			x_clamp = '0;
		end else if (x_c >= $signed(CW'(frame_width))) begin
			x_clamp = fw_m1[XW-1:0];
		end else begin
			x_clamp = x_c[XW-1:0];
		end
	end

	// Tap counters, in raster order of the kernel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			dr_q   <= '0;
			dc_q   <= '0;
			k_q    <= '0;
			tap_s1 <= '0;
		end else begin
			tap_s1.valid <= run_q;
			tap_s1.first <= run_q && (k_q == '0);
			tap_s1.last  <= run_q && last_dc && last_dr;
			if (start) begin
				run_q <= 1'b1;
				dr_q  <= '0;
				dc_q  <= '0;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + 1'b1;
				if (last_dc) begin
					dc_q <= '0;
					if (last_dr) begin
						run_q <= 1'b0;
					end else begin
						dr_q <= dr_q + 1'b1;
					end
				end else begin
					dc_q <= dc_q + 1'b1;
				end
			end
		end
	end

	// Clamped coordinates and kernel index of the tap
	always_ff @(posedge clk) begin
		y_s1 <= y_clamp;
		x_s1 <= x_clamp;
		k_s1 <= k_q;
	end

	assign tap       = tap_s1;
	assign kern_addr = k_s1;
	assign pix_addr  = AW'(y_s1) * AW'(MAX_WIDTH) + AW'(x_s1);

endmodule

FILE: hdl/rsf_mac.sv
// Multiply-accumulate unit: one tap per cycle, three colour channels at once.
// Depends on rsf_pkg.
module rsf_mac #(
	parameter int MAX_RADIUS = 3
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rsf_pkg::tap_t                           tap,
	input  logic signed [rsf_pkg::COEF_W-1:0]       coef,
	input  logic [rsf_pkg::PIX_W-1:0]               pixel,
	output logic signed [rsf_pkg::PROD_W +
		$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] acc_red,
	output logic signed [rsf_pkg::PROD_W +
		$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] acc_green,
	output logic signed [rsf_pkg::PROD_W +
		$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0] acc_blue,
	output logic                                    done
);

	import rsf_pkg::*;

	localparam int ACC_W = PROD_W + $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1));

	tap_t                    tap_s2;
	tap_t                    tap_s3;
	logic signed [PROD_W-1:0] p_red;
	logic signed [PROD_W-1:0] p_green;
	logic signed [PROD_W-1:0] p_blue;
	logic signed [PROD_W-1:0] p_red_s3;
	logic signed [PROD_W-1:0] p_green_s3;
	logic signed [PROD_W-1:0] p_blue_s3;
	logic signed [ACC_W-1:0]  acc_red_q;
	logic signed [ACC_W-1:0]  acc_green_q;
	logic signed [ACC_W-1:0]  acc_blue_q;
	logic                     done_q;

	// Products of the coefficient with each channel of the neighbour
	always_comb begin
		p_red   = coef * $signed({1'b0, pixel[CHAN_W-1:0]});
		p_green = coef * $signed({1'b0, pixel[2*CHAN_W-1:CHAN_W]});
		p_blue  = coef * $signed({1'b0, pixel[3*CHAN_W-1:2*CHAN_W]});
	end

	// Control delayed to line up with the store read data and the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s2 <= '0;
			tap_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tap_s2 <= tap;
			tap_s3 <= tap_s2;
			done_q <= tap_s3.valid && tap_s3.last;
		end
	end

	// Product registers and accumulators
	always_ff @(posedge clk) begin
		p_red_s3   <= p_red;
		p_green_s3 <= p_green;
		p_blue_s3  <= p_blue;
		if (tap_s3.valid) begin
			if (tap_s3.first) begin
				acc_red_q   <= ACC_W'(p_red_s3);
				acc_green_q <= ACC_W'(p_green_s3);
				acc_blue_q  <= ACC_W'(p_blue_s3);
			end else begin
				acc_red_q   <= acc_red_q + ACC_W'(p_red_s3);
				acc_green_q <= acc_green_q + ACC_W'(p_green_s3);
				acc_blue_q  <= acc_blue_q + ACC_W'(p_blue_s3);
			end
		end
	end

	assign acc_red   = acc_red_q;
	assign acc_green = acc_green_q;
	assign acc_blue  = acc_blue_q;
	assign done      = done_q;

endmodule

FILE: hdl/rsf_scale.sv
// Output scaling: one shared multiplier applies the scale to each channel
// sum in turn, then the result is shifted down and clamped to a byte.
// Depends on rsf_pkg.
module rsf_scale #(
	parameter int ACC_W = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ACC_W-1:0]            acc_red,
	input  logic signed [ACC_W-1:0]            acc_green,
	input  logic signed [ACC_W-1:0]            acc_blue,
	input  logic signed [rsf_pkg::COEF_W-1:0]  scale,
	input  logic                               take,
	output logic                               res_valid,
	output logic [rsf_pkg::CHAN_W-1:0]         red,
	output logic [rsf_pkg::CHAN_W-1:0]         green,
	output logic [rsf_pkg::CHAN_W-1:0]         blue
);

	import rsf_pkg::*;

	localparam int PW = ACC_W + COEF_W;

	logic                    run_q;
	logic [1:0]              ch_q;
	logic                    mul_v_s1;
	logic [1:0]              ch_s1;
	logic signed [PW-1:0]    prod_s1;
	logic signed [ACC_W-1:0] a_red_q;
	logic signed [ACC_W-1:0] a_green_q;
	logic signed [ACC_W-1:0] a_blue_q;
	logic signed [ACC_W-1:0] sel;
	logic [CHAN_W-1:0]       byte_c;
	logic [CHAN_W-1:0]       red_q;
	logic [CHAN_W-1:0]       green_q;
	logic [CHAN_W-1:0]       blue_q;
	logic                    res_valid_q;

	// Channel sum that goes through the multiplier this cycle
	always_comb begin
		case (ch_q)
			CH_RED:   sel = a_red_q;
			CH_GREEN: sel = a_green_q;
			CH_BLUE:  sel = a_blue_q;
			default:  sel = a_blue_q;
		endcase
	end

	// Shift right by 24 with truncation toward zero, then clamp to 0..255
	always_comb begin
		if (prod_s1[PW-1] || (prod_s1 == '0)) begin
			byte_c = '0;
		end else if (|prod_s1[PW-2:SCALE_SHIFT+CHAN_W]) begin
			byte_c = CHAN_MAX;
		end else begin
			byte_c = prod_s1[SCALE_SHIFT+CHAN_W-1:SCALE_SHIFT];
		end
	end

	// Channel sequencing and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			ch_q        <= CH_RED;
			mul_v_s1    <= 1'b0;
			ch_s1       <= CH_RED;
			res_valid_q <= 1'b0;
		end else begin
			mul_v_s1 <= run_q;
			ch_s1    <= ch_q;
			if (start) begin
				run_q <= 1'b1;
				ch_q  <= CH_RED;
			end else if (run_q) begin
				if (ch_q == CH_BLUE) begin
					run_q <= 1'b0;
				end else begin
					ch_q <= ch_q + 1'b1;
				end
			end
			if (mul_v_s1 && (ch_s1 == CH_BLUE)) begin
				res_valid_q <= 1'b1;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Latched sums, product register and result bytes
	always_ff @(posedge clk) begin
		if (start) begin
			a_red_q   <= acc_red;
			a_green_q <= acc_green;
			a_blue_q  <= acc_blue;
		end
		prod_s1 <= sel * scale;
		if (mul_v_s1) begin
			case (ch_s1)
				CH_RED:   red_q   <= byte_c;
				CH_GREEN: green_q <= byte_c;
				CH_BLUE:  blue_q  <= byte_c;
				default:  blue_q  <= byte_c;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

FILE: hdl/rgb_spatial_filter_replicate_edges_core.sv
// RGB spatial filter with replicated edges: the top level.
// Depends on rsf_pkg, rsf_ram, rsf_seq, rsf_mac and rsf_scale.
//
// Each input beat loads a kernel coefficient, writes a pixel into the frame
// store, or requests the filtered pixel at a row and column. A request walks
// the (2r+1)x(2r+1) window one tap per cycle through a single
// multiply-accumulate unit that serves red, green and blue together; the
// input is not ready until the result has entered the output register.
// Neighbours outside the frame read the nearest edge pixel. The frame store
// and kernel store power up holding anything; a request must only touch
// pixels and coefficients already written.
// Configuration writes are always taken and must only be made while idle.
module rgb_spatial_filter_replicate_edges_core #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_RADIUS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// row [8:0], column [17:9], coef_index [23:18], coef_value [39:24],
	// pixel_value [63:40]
	input  logic [rsf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// operation [1:0]
	input  logic [rsf_pkg::OP_W-1:0]            s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// red_out [7:0], green_out [15:8], blue_out [23:16], out_row [32:24],
	// out_column [41:33], zeros [47:42]
	output logic [rsf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rsf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import rsf_pkg::*;

	localparam int RW      = $clog2(MAX_RADIUS + 1);
	localparam int KTAPS   = (2*MAX_RADIUS + 1) * (2*MAX_RADIUS + 1);
	localparam int KW      = $clog2(KTAPS);
	localparam int FWW     = $clog2(MAX_WIDTH + 1);
	localparam int FHW     = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W   = PROD_W + KW;
	localparam int SZW_W   = ((FWW > SIZE_W) ? FWW : SIZE_W) + 1;
	localparam int SZH_W   = ((FHW > SIZE_W) ? FHW : SIZE_W) + 1;
	localparam int RZW     = ((RW > RAD_W) ? RW : RAD_W) + 1;
	localparam int ROWZ_W  = ((FHW > ROW_W) ? FHW : ROW_W) + 1;
	localparam int COLZ_W  = ((FWW > COL_W) ? FWW : COL_W) + 1;
	localparam int KZW     = ((KW > CIDX_W) ? KW : CIDX_W) + 2;
	localparam int OUT_PAD = OUT_DATA_W - 3*CHAN_W - ROW_W - COL_W;
	localparam int FW_RST  = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
	localparam int FH_RST  = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	// Input fields
	logic [OP_W-1:0]          in_op;
	logic [ROW_W-1:0]         in_row;
	logic [COL_W-1:0]         in_col;
	logic [CIDX_W-1:0]        in_cidx;
	logic [COEF_W-1:0]        in_coef;
	logic [PIX_W-1:0]         in_pix;
	logic                     in_beat;

	// Configuration
	logic [FWW-1:0]           fw_q;
	logic [FHW-1:0]           fh_q;
	logic [RW-1:0]            rad_q;
	logic signed [COEF_W-1:0] scale_q;
	logic [SIZE_W-1:0]        cfg_size;
	logic [SZW_W-1:0]         cfg_w_ext;
	logic [SZH_W-1:0]         cfg_h_ext;
	logic [RZW-1:0]           cfg_r_ext;
	logic [FWW-1:0]           fw_new;
	logic [FHW-1:0]           fh_new;
	logic [RW-1:0]            rad_new;

	// Control and request
	logic                     state_q;
	logic [ROW_W-1:0]         req_row_q;
	logic [COL_W-1:0]         req_col_q;
	logic                     start;

	// Stores
	logic                     pix_we;
	logic [AW-1:0]            pix_waddr;
	logic [AW-1:0]            pix_raddr;
	logic [PIX_W-1:0]         pix_rdata;
	logic                     kern_we;
	logic [KW-1:0]            kern_waddr;
	logic [KW-1:0]            kern_raddr;
	logic [COEF_W-1:0]        kern_rdata;

	// Datapath links
	tap_t                     tap;
	logic signed [ACC_W-1:0]  acc_red;
	logic signed [ACC_W-1:0]  acc_green;
	logic signed [ACC_W-1:0]  acc_blue;
	logic                     mac_done;
	logic                     fin_valid;
	logic [CHAN_W-1:0]        fin_red;
	logic [CHAN_W-1:0]        fin_green;
	logic [CHAN_W-1:0]        fin_blue;

	// Output register
	logic                     out_load;
	logic                     out_valid_q;
	logic [CHAN_W-1:0]        out_red_q;
	logic [CHAN_W-1:0]        out_green_q;
	logic [CHAN_W-1:0]        out_blue_q;
	logic [ROW_W-1:0]         out_row_q;
	logic [COL_W-1:0]         out_col_q;

	// Unpack the input beat
	assign in_op   = s_axis_tuser;
	assign in_row  = s_axis_tdata[ROW_W-1:0];
	assign in_col  = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_cidx = s_axis_tdata[ROW_W+COL_W+CIDX_W-1:ROW_W+COL_W];
	assign in_coef = s_axis_tdata[ROW_W+COL_W+CIDX_W+COEF_W-1:ROW_W+COL_W+CIDX_W];
	assign in_pix  = s_axis_tdata[IN_DATA_W-1:IN_DATA_W-PIX_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign start         = in_beat && (in_op == OP_COMPUTE);

	// Saturate the written frame size and radius into their legal ranges
	always_comb begin
		cfg_size  = cfg_data[SIZE_W-1:0];
		cfg_w_ext = SZW_W'(cfg_size);
		cfg_h_ext = SZH_W'(cfg_size);
		cfg_r_ext = RZW'(cfg_data[RAD_W-1:0]);
		if (cfg_size == '0) begin
			fw_new = FWW'(1);
			fh_new = FHW'(1);
		end else begin
			fw_new = (cfg_w_ext > SZW_W'(MAX_WIDTH)) ? FWW'(MAX_WIDTH) : cfg_w_ext[FWW-1:0];
			fh_new = (cfg_h_ext > SZH_W'(MAX_HEIGHT)) ? FHW'(MAX_HEIGHT) : cfg_h_ext[FHW-1:0];
		end
		rad_new = (cfg_r_ext > RZW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : cfg_r_ext[RW-1:0];
	end

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= FWW'(FW_RST);
			fh_q    <= FHW'(FH_RST);
			rad_q   <= RW'(1);
			scale_q <= 16'sd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q    <= fw_new;
				CFG_FRAME_HEIGHT: fh_q    <= fh_new;
				CFG_RADIUS:       rad_q   <= rad_new;
				CFG_SCALE:        scale_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Store writes; those outside the store are dropped
	assign pix_we = in_beat && (in_op == OP_WRITE_PIXEL) &&
		(ROWZ_W'(in_row) < ROWZ_W'(MAX_HEIGHT)) && (COLZ_W'(in_col) < COLZ_W'(MAX_WIDTH));
	assign pix_waddr  = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
	assign kern_we    = in_beat && (in_op == OP_LOAD_COEF) && (KZW'(in_cidx) < KZW'(KTAPS));
	assign kern_waddr = KW'(in_cidx);

	rsf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_pixel_store (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (in_pix),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	rsf_ram #(
		.WIDTH (COEF_W),
		.DEPTH (KTAPS)
	) u_kernel_store (
		.clk   (clk),
		.we    (kern_we),
		.waddr (kern_waddr),
		.wdata (in_coef),
		.raddr (kern_raddr),
		.rdata (kern_rdata)
	);

	rsf_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.row          (req_row_q),
		.column       (req_col_q),
		.radius       (rad_q),
		.frame_width  (fw_q),
		.frame_height (fh_q),
		.tap          (tap),
		.kern_addr    (kern_raddr),
		.pix_addr     (pix_raddr)
	);

	rsf_mac #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap       (tap),
		.coef      ($signed(kern_rdata)),
		.pixel     (pix_rdata),
		.acc_red   (acc_red),
		.acc_green (acc_green),
		.acc_blue  (acc_blue),
		.done      (mac_done)
	);

	rsf_scale #(
		.ACC_W (ACC_W)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mac_done),
		.acc_red   (acc_red),
		.acc_green (acc_green),
		.acc_blue  (acc_blue),
		.scale     (scale_q),
		.take      (out_load),
		.res_valid (fin_valid),
		.red       (fin_red),
		.green     (fin_green),
		.blue      (fin_blue)
	);

	// The result moves to the output register once that is free
	assign out_load = fin_valid && (!out_valid_q || m_axis_tready);

	// Request state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_BUSY;
				end
				ST_BUSY: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request coordinates and output payload
	always_ff @(posedge clk) begin
		if (start) begin
			req_row_q <= in_row;
			req_col_q <= in_col;
		end
		if (out_load) begin
			out_red_q   <= fin_red;
			out_green_q <= fin_green;
			out_blue_q  <= fin_blue;
			out_row_q   <= req_row_q;
			out_col_q   <= req_col_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_col_q, out_row_q,
		out_blue_q, out_green_q, out_red_q};

	// Datapath activity only while a request is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		tap.valid |-> (state_q == ST_BUSY))
		else $error("window tap issued outside a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_BUSY))
		else $error("accumulation finished outside a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> (state_q == ST_BUSY))
		else $error("scaled result pending outside a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ((state_q == ST_BUSY) && !fin_valid && !s_axis_tready))
		else $error("request did not start cleanly");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");

endmodule

FILE: bench/rsf_tb_pkg.sv
`timescale 1ns / 100ps
// Beat layouts and the scoreboard for the RGB spatial filter testbench.
// Depends on rsf_pkg for field widths, operation codes and register indexes.
package rsf_tb_pkg;

	import rsf_pkg::*;

	// Size of the frame store and of the kernel store in the block as built
	localparam int FRAME_MAX   = 512;
	localparam int KERNEL_TAPS = 49;
	localparam int MAX_REPORTS = 60;

	// Input beat on s_axis_tdata, lowest field last
	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic [COEF_W-1:0] coef;
		logic [CIDX_W-1:0] cidx;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} beat_in_t;

	// Output beat on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [5:0]        pad;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_result_t;

	// Keeps its own copy of the registers and both stores, works out the
	// filtered pixel for every accepted request and checks the output beats.
	class rsf_scoreboard;
		int cols_q  = FRAME_MAX;
		int rows_q  = FRAME_MAX;
		int rad_q   = 1;
		int scale_q = 4096;
		// Only written entries exist, so the stimulus can tell what is safe to read.
		logic [PIX_W-1:0] frame_img [int];
		int kern_taps [int];
		pixel_result_t pending_pixels [$];
		int results_seen = 0;
		int fails = 0;

		function int edge_clamp(int c, int lim);
			if (c < 0)
				return 0;
			if (c >= lim)
				return lim - 1;
			return c;
		endfunction

		// A size of zero acts as one; anything beyond the store saturates.
		function int fold_size(logic [SIZE_W-1:0] v);
			if (v == 0)
				return 1;
			return (v > FRAME_MAX) ? FRAME_MAX : int'(v);
		endfunction

		// Scale the window sum, keep the integer part and clamp to a byte.
		function logic [CHAN_W-1:0] finish_chan(longint acc);
			longint prod;
			prod = acc * longint'(scale_q);
			if (prod <= 0)
				return '0;
			prod = prod >>> SCALE_SHIFT;
			return (prod > 255) ? CHAN_MAX : prod[CHAN_W-1:0];
		endfunction

		function pixel_result_t filter_pixel(int row, int col);
			pixel_result_t res;
			longint acc_r, acc_g, acc_b;
			int side, y, x, w;
			logic [PIX_W-1:0] px;
			acc_r = 0;
			acc_g = 0;
			acc_b = 0;
			side = 2 * rad_q + 1;
			for (int dr = -rad_q; dr <= rad_q; dr++) begin
				y = edge_clamp(row + dr, rows_q);
				for (int dc = -rad_q; dc <= rad_q; dc++) begin
					x = edge_clamp(col + dc, cols_q);
					w = kern_taps[(dr + rad_q) * side + dc + rad_q];
					px = frame_img[y * FRAME_MAX + x];
					acc_r += longint'(w) * longint'(px[7:0]);
					acc_g += longint'(w) * longint'(px[15:8]);
					acc_b += longint'(w) * longint'(px[23:16]);
				end
			end
			res.red   = finish_chan(acc_r);
			res.green = finish_chan(acc_g);
			res.blue  = finish_chan(acc_b);
			res.row   = ROW_W'(row);
			res.col   = COL_W'(col);
			res.pad   = '0;
			return res;
		endfunction

		function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FRAME_WIDTH:  cols_q = fold_size(data[SIZE_W-1:0]);
				CFG_FRAME_HEIGHT: rows_q = fold_size(data[SIZE_W-1:0]);
				CFG_RADIUS:       rad_q = int'(data[RAD_W-1:0]);
				CFG_SCALE:        scale_q = int'($signed(data));
				default: ;
			endcase
		endfunction

		// Called for every accepted input beat, in order of acceptance.
		function void note_beat(logic [OP_W-1:0] op, beat_in_t b);
			case (op)
				OP_LOAD_COEF: begin
					if (b.cidx < KERNEL_TAPS)
						kern_taps[int'(b.cidx)] = int'($signed(b.coef));
				end
				OP_WRITE_PIXEL: frame_img[int'(b.row) * FRAME_MAX + int'(b.col)] = b.pix;
				OP_COMPUTE:     pending_pixels.push_back(filter_pixel(int'(b.row), int'(b.col)));
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		task check_field(string name, logic [8:0] got, logic [8:0] want, pixel_result_t ref_px);
			if (got !== want)
				report_mismatch($sformatf("%s is %0d, expected %0d, pixel (%0d,%0d)",
					name, got, want, ref_px.row, ref_px.col));
		endtask

		// Called for every accepted output beat.
		task check_pixel(logic [OUT_DATA_W-1:0] beat);
			pixel_result_t got, want;
			got = beat;
			results_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("pixel (%0d,%0d) arrived with no request outstanding",
					got.row, got.col));
				return;
			end
			want = pending_pixels.pop_front();
			check_field("red", 9'(got.red), 9'(want.red), want);
			check_field("green", 9'(got.green), 9'(want.green), want);
			check_field("blue", 9'(got.blue), 9'(want.blue), want);
			check_field("row", got.row, want.row, want);
			check_field("column", got.col, want.col, want);
			check_field("padding", 9'(got.pad), 9'(want.pad), want);
		endtask
	endclass

endpackage

FILE: bench/tb_rgb_spatial_filter_replicate_edges_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_spatial_filter_replicate_edges_core.
// Depends on rsf_pkg and on rsf_tb_pkg for the beat layouts and the scoreboard.
module tb_rgb_spatial_filter_replicate_edges_core;

	import rsf_pkg::*;
	import rsf_tb_pkg::*;

	localparam int ITEMS_TARGET = 1450;
	localparam int PHASE_ITEMS  = 160;
	localparam int MAX_GAP      = 17;
	localparam int HOLD_CYCLES  = 300;
	// Longest request is a 7x7 window plus the pipeline.
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rsf_scoreboard sb = new;

	int  n_beats = 0;
	int  n_loads = 0;
	int  n_writes = 0;
	int  n_requests = 0;
	int  n_ignored = 0;
	int  n_settings = 1;
	int  hot_row = 0;
	int  hot_col = 0;
	int  cycles = 0;
	bit  quiet_in = 1'b0;
	bit  quiet_out = 1'b0;

	rgb_spatial_filter_replicate_edges_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run-away guard.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Pixel values lean towards black, white and saturated channels.
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
				8'($urandom_range(0, 1) * 255)};
			default: return 24'($urandom);
		endcase
	endfunction

	// Mostly modest coefficients so that results land inside the byte range.
	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'(int'($urandom_range(0, 1024)) - 384);
		endcase
	endfunction

	// Coordinates near both edges, just outside the frame, in the hot spot or anywhere.
	function automatic int pick_coord(int lim, int hot);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 511);
			1: return $urandom_range(0, 3);
			2: return $urandom_range(lim > 4 ? lim - 4 : 0, lim + 3 > 511 ? 511 : lim + 3);
			default: return hot + $urandom_range(0, 7);
		endcase
	endfunction

	// Offer one beat after a random gap and wait until it is taken.
	task automatic push_beat(input logic [OP_W-1:0] op, input beat_in_t b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			quiet_in = !quiet_in;
		gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_beat(op, b);
		case (op)
			OP_LOAD_COEF: begin
				if (b.cidx < KERNEL_TAPS)
					n_loads++;
				else
					n_ignored++;
			end
			OP_WRITE_PIXEL: n_writes++;
			OP_COMPUTE:     n_requests++;
			default:        n_ignored++;
		endcase
		n_beats = n_loads + n_writes + n_requests;
	endtask

	task automatic load_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		beat_in_t b;
		b = {$urandom, $urandom};
		b.cidx = idx;
		b.coef = val;
		push_beat(OP_LOAD_COEF, b);
	endtask

	task automatic write_pixel(input int row, input int col, input logic [PIX_W-1:0] val);
		beat_in_t b;
		b = {$urandom, $urandom};
		b.row = ROW_W'(row);
		b.col = COL_W'(col);
		b.pix = val;
		push_beat(OP_WRITE_PIXEL, b);
	endtask

	// Request one filtered pixel, first loading any tap and writing any
	// neighbour that the window would read but that holds nothing yet.
	task automatic request_pixel(input int row, input int col);
		beat_in_t b;
		int rad, y, x;
		rad = sb.rad_q;
		for (int k = 0; k < (2 * rad + 1) * (2 * rad + 1); k++)
			if (!sb.kern_taps.exists(k))
				load_coef(CIDX_W'(k), rand_coef());
		for (int dr = -rad; dr <= rad; dr++) begin
			y = sb.edge_clamp(row + dr, sb.rows_q);
			for (int dc = -rad; dc <= rad; dc++) begin
				x = sb.edge_clamp(col + dc, sb.cols_q);
				if (!sb.frame_img.exists(y * FRAME_MAX + x))
					write_pixel(y, x, rand_pixel());
			end
		end
		b = {$urandom, $urandom};
		b.row = ROW_W'(row);
		b.col = COL_W'(col);
		push_beat(OP_COMPUTE, b);
	endtask

	task automatic random_item();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 11)
			request_pixel(pick_coord(sb.rows_q, hot_row), pick_coord(sb.cols_q, hot_col));
		else if (sel < 14)
			write_pixel(pick_coord(sb.rows_q, hot_row), pick_coord(sb.cols_q, hot_col),
				rand_pixel());
		else if (sel < 16)
			load_coef(CIDX_W'($urandom_range(0, KERNEL_TAPS - 1)), rand_coef());
		else if (sel == 16)
			load_coef(CIDX_W'($urandom_range(KERNEL_TAPS, 63)), rand_coef());
		else if (sel == 17)
			push_beat(OP_UNUSED, {$urandom, $urandom});
		else
			write_pixel($urandom_range(0, 511), $urandom_range(0, 511), rand_pixel());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_register(idx, data);
	endtask

	// Register settings per phase: the first few pin the extremes, the rest are
	// random. Bits above each field are filled at random as the block ignores them.
	task automatic set_phase(input int ph);
		int w, h, r;
		logic [CFG_DATA_W-1:0] s;
		case (ph)
			1: begin
				w = 1; h = 1; r = 0; s = 16'h7FFF;
			end
			2: begin
				w = 512; h = 512; r = 3; s = 16'h8000;
			end
			3: begin
				w = 0; h = 1023; r = 2; s = 16'd4096;
			end
			4: begin
				w = 700; h = 0; r = 1; s = 16'd0;
			end
			5: begin
				w = $urandom_range(2, 24);
				h = $urandom_range(2, 24);
				r = 3;
				s = 16'($urandom_range(2048, 8192));
			end
			default: begin
				w = $urandom_range(0, 1023);
				h = $urandom_range(0, 1023);
				r = $urandom_range(0, 3);
				s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1024, 12288));
			end
		endcase
		write_reg(CFG_FRAME_WIDTH, {6'($urandom), 10'(w)});
		write_reg(CFG_FRAME_HEIGHT, {6'($urandom), 10'(h)});
		write_reg(CFG_RADIUS, {14'($urandom), 2'(r)});
		write_reg(CFG_SCALE, s);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Let every outstanding request come out, then give loads and writes
	// still in the pipe time to settle before the registers change.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output side: random stalls, quiet stretches and two long hold-offs
	// that fill the block and stall its input.
	initial begin : result_sink
		int gap;
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet_out = !quiet_out;
			gap = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
			if (sb.results_seen == 20 || sb.results_seen == 120)
				gap = gap + HOLD_CYCLES;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_pixel(m_axis_tdata);
		end
	end

	initial begin : stimulus
		int phase_end;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Radius 1 kernel from the reset settings, with both coefficient extremes.
		load_coef(0, 16'h8000);
		load_coef(1, 16'h7FFF);
		load_coef(2, 16'h0000);
		load_coef(3, 16'h0001);
		load_coef(4, 16'd4096);
		load_coef(5, 16'hFFFF);
		load_coef(6, 16'd256);
		load_coef(7, 16'hFF00);
		load_coef(8, 16'd1024);

		// Loads beyond the kernel store and the unused operation change nothing.
		load_coef(6'd49, 16'h1234);
		load_coef(6'd63, 16'h7FFF);
		push_beat(OP_UNUSED, {$urandom, $urandom});

		// Top-left corner: the window hangs off both the top and the left edge.
		write_pixel(0, 0, 24'h000000);
		write_pixel(0, 1, 24'hFFFFFF);
		write_pixel(1, 0, 24'h0000FF);
		write_pixel(1, 1, 24'hFF00FF);
		request_pixel(0, 0);

		// Bottom-right corner, first with the extreme taps and then without.
		write_pixel(510, 510, 24'hFFFFFF);
		write_pixel(510, 511, 24'h00FF00);
		write_pixel(511, 510, 24'hFF0000);
		write_pixel(511, 511, 24'hFFFFFF);
		request_pixel(511, 511);
		load_coef(0, 16'h0000);
		load_coef(1, 16'h0000);
		request_pixel(511, 511);

		// Random phases, each under its own register settings.
		for (int ph = 0; n_beats < ITEMS_TARGET; ph++) begin
			if (ph > 0) begin
				wait_idle();
				set_phase(ph);
			end
			hot_row = (sb.rows_q > 8) ? $urandom_range(0, sb.rows_q - 8) : 0;
			hot_col = (sb.cols_q > 8) ? $urandom_range(0, sb.cols_q - 8) : 0;
			phase_end = n_beats + PHASE_ITEMS;
			while (n_beats < phase_end && n_beats < ITEMS_TARGET)
				random_item();
		end
		wait_idle();

		$display("Ran %0d beats under %0d register settings: %0d coefficient loads, %0d pixel writes, %0d filter requests, %0d ignored.",
			n_beats + n_ignored, n_settings, n_loads, n_writes, n_requests, n_ignored);
		$display("Checked %0d filtered pixels with %0d mismatches.", sb.results_seen, sb.fails);
		if (sb.fails == 0 && sb.pending_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
